// ===== rtl/tlci_pkg.sv =====
// ----------------------------------------------------------------------------
// tlci_pkg
// shared types, field widths and codes for the text line/column index
// ----------------------------------------------------------------------------
package tlci_pkg;

    // default capacities
    localparam int MAX_BYTES_DEF = 65536;
    localparam int MAX_LINES_DEF = 4096;

    // entries in the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // field widths
    localparam int ACT_W  = 2;
    localparam int DATA_W = 8;
    localparam int OFF_W  = 17;
    localparam int LINE_W = 16;
    localparam int COL_W  = 17;
    localparam int LNUM_W = 13;

    // action codes on the input tuser
    localparam logic [ACT_W-1:0] ACT_LOAD    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_OFF2POS = 2'd1;
    localparam logic [ACT_W-1:0] ACT_POS2OFF = 2'd2;

    localparam logic [DATA_W-1:0] NEWLINE = 8'd10;

    // command kind after classification
    typedef enum logic [1:0] {
        K_LOAD,
        K_OFFQ,
        K_POSQ
    } t_kind;

    // input tdata layout, last field in the lowest bits
    typedef struct packed {
        logic [COL_W-1:0]  query_column;
        logic [LINE_W-1:0] query_line;
        logic [OFF_W-1:0]  query_offset;
        logic [DATA_W-1:0] data_byte;
    } t_in_data;

    localparam int IN_W      = $bits(t_in_data);
    localparam int S_TDATA_W = ((IN_W + 7) / 8) * 8;

    typedef struct packed {
        t_kind    kind;
        t_in_data payload;
    } t_cmd;

    // result tdata layout, last field in the lowest bits
    typedef struct packed {
        logic              overflow;
        logic              offset_valid;
        logic [OFF_W-1:0]  offset_result;
        logic [COL_W-1:0]  col_no;
        logic [LNUM_W-1:0] line_no;
    } t_res;

    localparam int RES_W     = $bits(t_res);
    localparam int M_TDATA_W = ((RES_W + 7) / 8) * 8;

endpackage

// ===== rtl/tlci_front.sv =====
// ----------------------------------------------------------------------------
// tlci_front
// input beat register: decodes the action and drops unused codes
// ----------------------------------------------------------------------------
module tlci_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [tlci_pkg::S_TDATA_W-1:0] s_axis_tdata,
    input  logic [tlci_pkg::ACT_W-1:0]     s_axis_tuser,
    output logic                           o_cmd_valid,
    input  logic                           i_cmd_ready,
    output tlci_pkg::t_cmd                 o_cmd
);

    logic           r_valid;
    logic           n_valid;
    tlci_pkg::t_cmd r_cmd;
    tlci_pkg::t_cmd n_cmd;
    logic           accept;

    assign s_axis_tready = !r_valid || i_cmd_ready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_valid = r_valid && !i_cmd_ready;
        n_cmd   = r_cmd;
        if (accept) begin
            n_cmd.payload = tlci_pkg::t_in_data'(s_axis_tdata[tlci_pkg::IN_W-1:0]);
            n_valid       = 1'b1;
            unique case (s_axis_tuser)
                tlci_pkg::ACT_LOAD:    n_cmd.kind = tlci_pkg::K_LOAD;
                tlci_pkg::ACT_OFF2POS: n_cmd.kind = tlci_pkg::K_OFFQ;
                tlci_pkg::ACT_POS2OFF: n_cmd.kind = tlci_pkg::K_POSQ;
                default: begin
                    // unused code: swallowed, nothing goes on
                    n_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

endmodule

// ===== rtl/tlci_queue.sv =====
// ----------------------------------------------------------------------------
// tlci_queue
// short command queue between front and back
// ----------------------------------------------------------------------------
module tlci_queue #(
    parameter int DEPTH = tlci_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  tlci_pkg::t_cmd i_cmd,
    output logic           o_valid,
    input  logic           i_ready,
    output tlci_pkg::t_cmd o_cmd
);

    // depth of at least two
    localparam int PW = $clog2(DEPTH);
    localparam int CNW = $clog2(DEPTH + 1);

    tlci_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0]  r_wp;
    logic [PW-1:0]  r_rp;
    logic [CNW-1:0] r_cnt;
    logic           push;
    logic           pop;

    assign o_ready = (r_cnt != CNW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + CNW'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - CNW'(1);
            end
        end
    end

endmodule

// ===== rtl/tlci_back.sv =====
// ----------------------------------------------------------------------------
// tlci_back
// executes loads and queries: newline table, binary search, result register
// ----------------------------------------------------------------------------
module tlci_back #(
    parameter int MAX_BYTES = tlci_pkg::MAX_BYTES_DEF,
    parameter int MAX_LINES = tlci_pkg::MAX_LINES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cmd_valid,
    output logic           o_cmd_ready,
    input  tlci_pkg::t_cmd i_cmd,
    output logic           o_res_valid,
    input  logic           i_res_ready,
    output tlci_pkg::t_res o_res
);

    localparam int BCW = $clog2(MAX_BYTES + 1);
    localparam int OFW = $clog2(MAX_BYTES);
    localparam int NCW = $clog2(MAX_LINES + 1);
    localparam int AW  = $clog2(MAX_LINES);
    localparam int M1  = (BCW > tlci_pkg::COL_W) ? BCW : tlci_pkg::COL_W;
    localparam int M2  = (M1 > NCW) ? M1 : NCW;
    localparam int CW  = M2 + 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SRCH,
        ST_OFIN,
        ST_PFIN,
        ST_RES
    } t_state;

    t_state         r_state, n_state;
    logic [BCW-1:0] r_bytes, n_bytes;
    logic [NCW-1:0] r_nls, n_nls;
    logic           r_ovf, n_ovf;
    logic [NCW-1:0] r_lo, n_lo;
    logic [NCW-1:0] r_hi, n_hi;
    logic [AW-1:0]  r_mid, n_mid;
    tlci_pkg::t_cmd r_q, n_q;
    tlci_pkg::t_res r_res, n_res;
    logic           r_out_valid, n_out_valid;
    tlci_pkg::t_res r_out, n_out;

    logic [OFW-1:0] r_table [MAX_LINES];
    logic [OFW-1:0] r_rd_data;

    logic           rd_en;
    logic [AW-1:0]  rd_addr;
    logic           wr_en;
    tlci_pkg::t_cmd cur;
    logic           lt;
    logic [NCW-1:0] lo2;
    logic [NCW-1:0] hi2;
    logic [AW-1:0]  mid2;
    logic [CW-1:0]  pos;

    assign o_cmd_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state     = r_state;
        n_bytes     = r_bytes;
        n_nls       = r_nls;
        n_ovf       = r_ovf;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_q         = r_q;
        n_res       = r_res;
        n_out_valid = r_out_valid && !i_res_ready;
        n_out       = r_out;
        rd_en       = 1'b0;
        rd_addr     = r_mid;
        wr_en       = 1'b0;

        cur  = (r_state == ST_IDLE) ? i_cmd : r_q;
        // one search step: table entry at mid against the query offset
        lt   = (CW'(r_rd_data) < CW'(cur.payload.query_offset));
        lo2  = lt ? NCW'(r_mid) + NCW'(1) : r_lo;
        hi2  = lt ? r_hi : NCW'(r_mid);
        mid2 = AW'(lo2 + ((hi2 - lo2) >> 1));
        // line start plus column minus one, column zero counts as one
        pos  = ((r_state == ST_PFIN) ? CW'(r_rd_data) + CW'(1) : CW'(0))
             + CW'(cur.payload.query_column)
             - CW'(cur.payload.query_column != '0);

        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    n_q   = i_cmd;
                    n_res = '0;
                    unique case (i_cmd.kind)
                        tlci_pkg::K_LOAD: begin
                            if (r_bytes == BCW'(MAX_BYTES)) begin
                                n_ovf = 1'b1;
                            end else if (i_cmd.payload.data_byte == tlci_pkg::NEWLINE) begin
                                if (r_nls == NCW'(MAX_LINES)) begin
                                    n_ovf = 1'b1;
                                end else begin
                                    wr_en   = 1'b1;
                                    n_nls   = r_nls + NCW'(1);
                                    n_bytes = r_bytes + BCW'(1);
                                end
                            end else begin
                                n_bytes = r_bytes + BCW'(1);
                            end
                        end
                        tlci_pkg::K_OFFQ: begin
                            n_state = ST_RES;
                            if (CW'(i_cmd.payload.query_offset) <= CW'(r_bytes)) begin
                                if (r_nls != '0) begin
                                    n_lo    = '0;
                                    n_hi    = r_nls;
                                    n_mid   = AW'(r_nls >> 1);
                                    rd_en   = 1'b1;
                                    rd_addr = AW'(r_nls >> 1);
                                    n_state = ST_SRCH;
                                end else begin
                                    n_res.line_no = tlci_pkg::LNUM_W'(1);
                                    n_res.col_no  = tlci_pkg::COL_W'(
                                        CW'(i_cmd.payload.query_offset) + CW'(1));
                                end
                            end
                        end
                        tlci_pkg::K_POSQ: begin
                            n_state = ST_RES;
                            if (i_cmd.payload.query_line != '0 &&
                                CW'(i_cmd.payload.query_line) <= CW'(r_nls) + CW'(1)) begin
                                if (i_cmd.payload.query_line >= tlci_pkg::LINE_W'(2)) begin
                                    rd_en   = 1'b1;
                                    rd_addr = AW'(i_cmd.payload.query_line
                                                  - tlci_pkg::LINE_W'(2));
                                    n_state = ST_PFIN;
                                end else if (pos <= CW'(r_bytes)) begin
                                    n_res.offset_result = tlci_pkg::OFF_W'(pos);
                                    n_res.offset_valid  = 1'b1;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_SRCH: begin
                n_lo = lo2;
                n_hi = hi2;
                if (lo2 < hi2) begin
                    n_mid   = mid2;
                    rd_en   = 1'b1;
                    rd_addr = mid2;
                end else if (lo2 != '0) begin
                    // fetch the newline that ends the previous line
                    rd_en   = 1'b1;
                    rd_addr = AW'(lo2 - NCW'(1));
                    n_state = ST_OFIN;
                end else begin
                    n_res.line_no = tlci_pkg::LNUM_W'(1);
                    n_res.col_no  = tlci_pkg::COL_W'(
                        CW'(cur.payload.query_offset) + CW'(1));
                    n_state = ST_RES;
                end
            end
            ST_OFIN: begin
                n_res.line_no = tlci_pkg::LNUM_W'(CW'(r_lo) + CW'(1));
                n_res.col_no  = tlci_pkg::COL_W'(
                    CW'(cur.payload.query_offset) - CW'(r_rd_data));
                n_state = ST_RES;
            end
            ST_PFIN: begin
                if (pos <= CW'(r_bytes)) begin
                    n_res.offset_result = tlci_pkg::OFF_W'(pos);
                    n_res.offset_valid  = 1'b1;
                end
                n_state = ST_RES;
            end
            ST_RES: begin
                if (!r_out_valid || i_res_ready) begin
                    n_out_valid    = 1'b1;
                    n_out          = r_res;
                    n_out.overflow = r_ovf;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_mid <= n_mid;
        r_q   <= n_q;
        r_res <= n_res;
        r_out <= n_out;
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_bytes     <= '0;
            r_nls       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bytes     <= n_bytes;
            r_nls       <= n_nls;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    // newline table, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_table[r_nls[AW-1:0]] <= r_bytes[OFW-1:0];
        end
        if (rd_en) begin
            r_rd_data <= r_table[rd_addr];
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

// ===== rtl/text_line_column_index_top.sv =====
// ----------------------------------------------------------------------------
// text_line_column_index_top
// line/column index of a text document loaded byte by byte
// ----------------------------------------------------------------------------
//
// channel   dir  beat content
// s_axis    in   tuser: action
//                tdata: data_byte, query_offset, query_line, query_column
// m_axis    out  tdata: line_no, col_no, offset_result,
//                       offset_valid, overflow (one beat per query)
//
// a beat reaches the back end through the front register and then the command
// queue
// the back end handles a load in its idle state; a position query for line one
// or out of range goes straight to the result state, any other first fetches
// its line start; an offset query spends one search state per search step,
// plus one more to fetch the start of any line but the first; a search takes
// at most ceil(log2(lines + 1)) steps, and the binary search reads one newline
// table entry per cycle through the table's single read port
// reset is synchronous and clears state, counters, pointers and flags only; the
// newline table holds garbage until written and needs no clearing pass
// the front register and the command queue take up to three beats while the
// back end searches or waits for the result register to drain on m_axis_tready
//
module text_line_column_index_top #(
    parameter int MAX_BYTES = tlci_pkg::MAX_BYTES_DEF,
    parameter int MAX_LINES = tlci_pkg::MAX_LINES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // data_byte, query_offset, query_line, query_column, zero padding
    input  logic [tlci_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // action
    input  logic [tlci_pkg::ACT_W-1:0]     s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // line_no, col_no, offset_result, offset_valid, overflow, padding
    output logic [tlci_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    // classified beat from front register into the queue
    logic           front_valid;
    logic           front_ready;
    tlci_pkg::t_cmd front_cmd;

    // queue head to the back end
    logic           q_valid;
    logic           q_ready;
    tlci_pkg::t_cmd q_cmd;

    tlci_pkg::t_res res;

    tlci_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_cmd_valid   (front_valid),
        .i_cmd_ready   (front_ready),
        .o_cmd         (front_cmd)
    );

    tlci_queue #(
        .DEPTH (tlci_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (front_ready),
        .i_cmd   (front_cmd),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_cmd   (q_cmd)
    );

    tlci_back #(
        .MAX_BYTES (MAX_BYTES),
        .MAX_LINES (MAX_LINES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .o_cmd_ready (q_ready),
        .i_cmd       (q_cmd),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res       (res)
    );

    // result fields from the lowest bit up, padded to whole bytes
    assign m_axis_tdata = {{(tlci_pkg::M_TDATA_W - tlci_pkg::RES_W){1'b0}}, res};

endmodule

// ===== rtl/tlci_checker.sv =====
// ----------------------------------------------------------------------------
// tlci_checker
// port-level checks on the result stream, bound to the top level
// ----------------------------------------------------------------------------
module tlci_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_m_tvalid,
    input logic                           i_m_tready,
    input logic [tlci_pkg::M_TDATA_W-1:0] i_m_tdata
);

    tlci_pkg::t_res res;
    logic           r_seen_ovf;

    assign res = tlci_pkg::t_res'(i_m_tdata[tlci_pkg::RES_W-1:0]);

    // overflow seen on an earlier result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_ovf <= 1'b0;
        end else if (i_m_tvalid && i_m_tready && res.overflow) begin
            r_seen_ovf <= 1'b1;
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid)
        else $error("result beat withdrawn while stalled");

    a_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && r_seen_ovf |-> res.overflow)
        else $error("overflow flag cleared after being reported");

    a_line0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && res.line_no == '0 |-> res.col_no == '0)
        else $error("column given for an invalid line");

    a_offq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && res.line_no != '0 |->
            !res.offset_valid && res.offset_result == '0)
        else $error("offset fields set on an offset query result");

    a_pinv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !res.offset_valid |-> res.offset_result == '0)
        else $error("offset given without valid flag");

endmodule

bind text_line_column_index_top tlci_checker u_tlci_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata)
);

// ===== test/text_line_column_index_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_line_column_index_top_tb
// self-checking bench for the text line/column index
// ----------------------------------------------------------------------------
//
// a queue of pending beats, filled by the sequence below, feeds a driver that
// changes s_axis at the falling edge; a monitor at the rising edge runs every
// accepted beat through a behavioural line index and checks each result beat
// on m_axis against the oldest predicted one, field by field
//
// the document only grows, so the run goes from an empty text through a few
// directed edge cases and a couple of thousand random edits and queries,
// idling first on the receive side, then on the send side, then not at all
//
module text_line_column_index_top_tb;

    localparam int DOC_CAPACITY = tlci_pkg::MAX_BYTES_DEF;
    localparam int EOL_CAPACITY = tlci_pkg::MAX_LINES_DEF;
    localparam logic [tlci_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;

    // about 2k beats, about 1.1k of them queries, with both sides idling and
    // one long hold-off
    localparam int CYCLE_LIMIT = 200_000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 64;

    typedef struct packed {
        logic [tlci_pkg::ACT_W-1:0] act;
        tlci_pkg::t_in_data         fields;
    } t_doc_beat;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [tlci_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;
    logic [tlci_pkg::ACT_W-1:0]     s_axis_tuser = '0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [tlci_pkg::M_TDATA_W-1:0] m_axis_tdata;

    // beats waiting to be offered, and results still owed by the block
    t_doc_beat      pending[$];
    tlci_pkg::t_res expected_res[$];

    int unsigned offered_beats = 0;
    int unsigned accepted_beats = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned holds_asked = 0;

    // document as the sequence sees it when it queues a beat
    int unsigned gen_bytes = 0;
    int unsigned gen_lines = 0;

    // document as the block should hold it, updated on acceptance
    int unsigned doc_size = 0;
    int unsigned eol_count = 0;
    logic        ovf_flag = 1'b0;
    logic [15:0] eol_table [EOL_CAPACITY];

    text_line_column_index_top #(
        .MAX_BYTES (DOC_CAPACITY),
        .MAX_LINES (EOL_CAPACITY)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // behavioural index: applies one accepted beat, queues the result it owes
    task automatic index_predict(input logic [tlci_pkg::ACT_W-1:0] act,
                                 input tlci_pkg::t_in_data d);
        int unsigned    lo;
        int unsigned    hi;
        int unsigned    mid;
        int unsigned    start;
        int unsigned    pos;
        int unsigned    qoff;
        int unsigned    qline;
        int unsigned    qcol;
        tlci_pkg::t_res r;
        r = '0;
        qoff = d.query_offset;
        qline = d.query_line;
        qcol = d.query_column;
        case (act)
            tlci_pkg::ACT_LOAD: begin
                if (doc_size >= DOC_CAPACITY) begin
                    ovf_flag = 1'b1;
                end else if (d.data_byte == tlci_pkg::NEWLINE) begin
                    // a newline that finds the table full is not counted as a byte
                    if (eol_count >= EOL_CAPACITY) begin
                        ovf_flag = 1'b1;
                    end else begin
                        eol_table[eol_count] = doc_size[15:0];
                        eol_count++;
                        doc_size++;
                    end
                end else begin
                    doc_size++;
                end
            end
            tlci_pkg::ACT_OFF2POS: begin
                if (qoff <= doc_size) begin
                    // first newline at or after the offset
                    lo = 0;
                    hi = eol_count;
                    while (lo < hi) begin
                        mid = lo + ((hi - lo) >> 1);
                        if (eol_table[mid] < qoff) lo = mid + 1;
                        else hi = mid;
                    end
                    start = (lo > 0) ? eol_table[lo - 1] + 1 : 0;
                    r.line_no = tlci_pkg::LNUM_W'(lo + 1);
                    r.col_no = tlci_pkg::COL_W'(qoff - start + 1);
                end
                r.overflow = ovf_flag;
                expected_res.push_back(r);
            end
            tlci_pkg::ACT_POS2OFF: begin
                if (qline != 0 && qline - 1 <= eol_count) begin
                    pos = (qline >= 2) ? eol_table[qline - 2] + 1 : 0;
                    if (qcol > 0) pos += qcol - 1;
                    if (pos <= doc_size) begin
                        r.offset_result = tlci_pkg::OFF_W'(pos);
                        r.offset_valid = 1'b1;
                    end
                end
                r.overflow = ovf_flag;
                expected_res.push_back(r);
            end
            default: begin
                // unused action code: no effect, no result
            end
        endcase
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    // watchdog
    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("text_line_column_index_top regression: fail");
            $finish;
        end
    end

    // monitor: result beats are checked before the input beat of the same edge
    // is predicted, so an expectation is always queued ahead of its result
    always @(posedge i_clk) begin : monitor
        tlci_pkg::t_res got;
        tlci_pkg::t_res want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = tlci_pkg::t_res'(m_axis_tdata[tlci_pkg::RES_W-1:0]);
                if (expected_res.size() == 0) begin
                    $error("result beat with no query outstanding");
                    mismatches++;
                end else begin
                    want = expected_res.pop_front();
                    compare_field("line_no", want.line_no, got.line_no);
                    compare_field("col_no", want.col_no, got.col_no);
                    compare_field("offset_result", want.offset_result, got.offset_result);
                    compare_field("offset_valid", want.offset_valid, got.offset_valid);
                    compare_field("overflow", want.overflow, got.overflow);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                accepted_beats = accepted_beats + 1;
                index_predict(s_axis_tuser,
                              tlci_pkg::t_in_data'(s_axis_tdata[tlci_pkg::IN_W-1:0]));
            end
        end
    end

    // driver: a beat stays on the bus until taken, then the next one or a gap
    always @(negedge i_clk) begin : driver
        t_doc_beat b;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (accepted_beats == offered_beats) begin
            if (pending.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                b = pending.pop_front();
                s_axis_tuser <= b.act;
                s_axis_tdata <= {{(tlci_pkg::S_TDATA_W - tlci_pkg::IN_W){1'b0}}, b.fields};
                s_axis_tvalid <= 1'b1;
                offered_beats = offered_beats + 1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, plus long hold-offs on request
    always @(negedge i_clk) begin : receiver
        int unsigned hold_left;
        int unsigned holds_taken;
        if (!i_rst_n) begin
            hold_left = 0;
            holds_taken = 0;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (holds_taken != holds_asked) begin
            holds_taken = holds_taken + 1;
            hold_left = HOLD_CYCLES - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    task automatic queue_beat(input logic [tlci_pkg::ACT_W-1:0] act,
                              input int unsigned data,
                              input int unsigned qoff, input int unsigned qline,
                              input int unsigned qcol);
        t_doc_beat b;
        b.act = act;
        b.fields.data_byte = data[tlci_pkg::DATA_W-1:0];
        b.fields.query_offset = qoff[tlci_pkg::OFF_W-1:0];
        b.fields.query_line = qline[tlci_pkg::LINE_W-1:0];
        b.fields.query_column = qcol[tlci_pkg::COL_W-1:0];
        pending.push_back(b);
        if (act == tlci_pkg::ACT_LOAD && gen_bytes < DOC_CAPACITY) begin
            if (b.fields.data_byte != tlci_pkg::NEWLINE) begin
                gen_bytes++;
            end else if (gen_lines < EOL_CAPACITY) begin
                gen_lines++;
                gen_bytes++;
            end
        end
    endtask

    // unused fields of every load and query beat carry random junk
    task automatic queue_load(input int unsigned data);
        queue_beat(tlci_pkg::ACT_LOAD, data, $urandom_range(131071, 0),
                   $urandom_range(65535, 0), $urandom_range(131071, 0));
    endtask

    task automatic queue_offq(input int unsigned qoff);
        queue_beat(tlci_pkg::ACT_OFF2POS, $urandom_range(255, 0), qoff,
                   $urandom_range(65535, 0), $urandom_range(131071, 0));
    endtask

    task automatic queue_posq(input int unsigned qline, input int unsigned qcol);
        queue_beat(tlci_pkg::ACT_POS2OFF, $urandom_range(255, 0),
                   $urandom_range(131071, 0), qline, qcol);
    endtask

    // mostly loads and queries that land inside the document, some noise
    task automatic queue_random(input int n);
        int unsigned pick;
        int unsigned qline;
        int unsigned qcol;
        repeat (n) begin
            pick = $urandom_range(99, 0);
            if (pick < 40) begin
                queue_load(($urandom_range(5, 0) == 0) ? tlci_pkg::NEWLINE
                                                       : $urandom_range(255, 0));
            end else if (pick < 66) begin
                pick = $urandom_range(99, 0);
                if (pick < 85) queue_offq($urandom_range(gen_bytes, 0));
                else if (pick < 90) queue_offq(gen_bytes + 1);
                else queue_offq($urandom_range(131071, 0));
            end else if (pick < 96) begin
                qline = ($urandom_range(99, 0) < 85) ? $urandom_range(gen_lines + 1, 1)
                                                     : $urandom_range(65535, 0);
                pick = $urandom_range(99, 0);
                if (pick < 70) qcol = $urandom_range(40, 0);
                else if (pick < 90) qcol = $urandom_range(gen_bytes + 2, 0);
                else qcol = $urandom_range(131071, 0);
                queue_posq(qline, qcol);
            end else begin
                queue_beat(ACT_UNUSED, $urandom_range(255, 0), $urandom_range(131071, 0),
                           $urandom_range(65535, 0), $urandom_range(131071, 0));
            end
        end
    endtask

    // sender stays quiet until every beat is taken and every result is back
    task automatic wait_drained();
        while (pending.size() != 0 || accepted_beats != offered_beats
               || expected_res.size() != 0) begin
            @(negedge i_clk);
        end
        @(posedge i_clk);
    endtask

    initial begin : sequence_main
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(posedge i_clk);

        // receiver-side idling first
        send_idle_pct = 19;
        recv_idle_pct = 51;

        // empty document: offset equal to size, beyond size, bad lines
        queue_offq(0);
        queue_offq(1);
        queue_posq(0, 1);
        queue_posq(1, 0);
        queue_posq(2, 1);
        queue_beat(ACT_UNUSED, 255, 131071, 65535, 131071);
        // extremes of the byte, back-to-back newlines, newline as last byte
        queue_load(8'h00);
        queue_load(8'hff);
        queue_load(tlci_pkg::NEWLINE);
        queue_load(tlci_pkg::NEWLINE);
        queue_load(8'h41);
        queue_load(tlci_pkg::NEWLINE);
        queue_offq(2);
        queue_offq(3);
        queue_offq(6);
        queue_offq(7);
        queue_offq(65536);
        queue_posq(4, 1);
        queue_posq(4, 2);
        queue_posq(5, 1);
        queue_posq(65535, 65536);
        queue_posq(2, 0);
        queue_posq(1, 65536);
        queue_random(650);
        wait_drained();

        // sender-side idling, with a long receiver hold-off over a run of queries
        send_idle_pct = 51;
        recv_idle_pct = 19;
        queue_random(300);
        wait_drained();
        holds_asked++;
        repeat (40) queue_offq($urandom_range(gen_bytes, 0));
        queue_random(300);
        wait_drained();

        // no idling: queries at the end of the document, then random traffic
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_offq(gen_bytes);
        queue_posq(gen_lines + 1, 1);
        queue_posq(gen_lines + 2, 1);
        queue_random(650);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_res.size() == 0) begin
            $display("text_line_column_index_top regression: pass");
        end else begin
            $display("text_line_column_index_top regression: fail");
        end
        $finish;
    end

endmodule
